// File: rtl/core/energy_pulse_frequency_meter_defines.svh
// Assertion macros used by the checker of the pulse frequency meter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ENERGY_PULSE_FREQUENCY_METER_DEFINES_SVH
`define ENERGY_PULSE_FREQUENCY_METER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPFM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPFM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/epfm_pkg.sv
package epfm_pkg;

    localparam int unsigned TIME_W    = 64;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned MUXW_W    = 32;
    localparam int unsigned READ_W    = 40;
    localparam int unsigned SCALE_W   = 30;
    // A 32-bit count times the scale always fits in 62 bits.
    localparam int unsigned NUM_W     = 62;
    localparam int unsigned DIV_CNT_W = 6;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;

    localparam logic [SCALE_W-1:0]   SCALE_MHZ       = 30'd1000000000;
    localparam logic [31:0]          SWITCH_US_RESET = 32'd500000;
    localparam logic [READ_W-1:0]    READ_MAX        = '1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST        = DIV_CNT_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        OP_EDGES       = 3'd0,
        OP_READ_VOLT   = 3'd1,
        OP_READ_CURR   = 3'd2,
        OP_READ_POWER  = 3'd3,
        OP_READ_ENERGY = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_POWER_EN   = 3'd0,
        REG_MUX_EN     = 3'd1,
        REG_SELECT_EN  = 3'd2,
        REG_CURR_LEVEL = 3'd3,
        REG_SWITCH_US  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_full;
    } sts_t;

    typedef struct packed {
        logic        power_en;
        logic        mux_en;
        logic        select_en;
        logic        curr_level;
        logic [31:0] switch_us;
    } cfg_t;

endpackage

// File: rtl/core/epfm_ctrl.sv
module epfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_ready,
    input  epfm_pkg::sts_t  sts,
    output logic            in_ready,
    output epfm_pkg::cmd_t  cmd
);
    import epfm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_div ? ST_MUL : ST_WRITE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // The output register is free, or is emptied in this cycle.
                if (!sts.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/epfm_dp.sv
module epfm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  epfm_pkg::cmd_t                cmd,
    output epfm_pkg::sts_t                sts,
    input  epfm_pkg::cfg_t                cfg,
    input  logic [2:0]                    operation,
    input  logic [epfm_pkg::TIME_W-1:0]   now_us,
    input  logic                          power_edge,
    input  logic                          mux_edge,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [epfm_pkg::READ_W-1:0]   reading_mhz,
    output logic [epfm_pkg::TIME_W-1:0]   total_pulses,
    output logic                          select_level,
    output logic                          select_update
);
    import epfm_pkg::*;

    // Captured transaction and the time differences taken against stored edge times.
    op_t                op_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               pe_reg;
    logic               me_reg;
    logic [TIME_W-1:0]  pdiff_reg;
    logic [MUXW_W-1:0]  mdiff_reg;
    logic [TIME_W-1:0]  sdiff_reg;

    // Measurement state.
    logic [TIME_W-1:0]  last_power_reg;
    logic [TIME_W-1:0]  last_mux_reg;
    logic [TIME_W-1:0]  last_switch_reg;
    logic [TIME_W-1:0]  power_sum_reg;
    logic [CNT_W-1:0]   power_cnt_reg;
    logic [TIME_W-1:0]  total_reg;
    logic [TIME_W-1:0]  curr_sum_reg;
    logic [CNT_W-1:0]   curr_cnt_reg;
    logic [TIME_W-1:0]  volt_sum_reg;
    logic [CNT_W-1:0]   volt_cnt_reg;
    logic               meas_curr_reg;
    logic               update_reg;
    logic               has_quot_reg;

    // Divider.
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_W-1:0]    den_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Output register.
    logic               out_valid_reg;
    logic [READ_W-1:0]  reading_out_reg;
    logic [TIME_W-1:0]  total_out_reg;
    logic               level_out_reg;
    logic               update_out_reg;

    logic               is_read;
    logic [CNT_W-1:0]   sel_cnt;
    logic [TIME_W-1:0]  sel_sum;
    logic               power_hit;
    logic               mux_hit;
    logic               switch_due;
    logic [NUM_W-1:0]   product;
    logic [TIME_W:0]    rem_shift;
    logic [TIME_W+1:0]  rem_sub;
    logic               rem_ge;
    logic [TIME_W-1:0]  rem_next;
    logic [NUM_W-1:0]   num_next;
    logic [READ_W-1:0]  reading_next;

    always_comb
    begin
        is_read = 1'b1;
        sel_cnt = '0;
        sel_sum = '0;
        unique case (op_reg)
            OP_READ_VOLT:
            begin
                sel_cnt = volt_cnt_reg;
                sel_sum = volt_sum_reg;
            end
            OP_READ_CURR:
            begin
                sel_cnt = curr_cnt_reg;
                sel_sum = curr_sum_reg;
            end
            OP_READ_POWER:
            begin
                sel_cnt = power_cnt_reg;
                sel_sum = power_sum_reg;
            end
            default:
            begin
                is_read = 1'b0;
            end
        endcase
    end

    assign power_hit  = (op_reg == OP_EDGES) && cfg.power_en && pe_reg;
    assign mux_hit    = (op_reg == OP_EDGES) && cfg.mux_en && me_reg;
    assign switch_due = sdiff_reg > {{(TIME_W-32){1'b0}}, cfg.switch_us};

    assign product   = {{(NUM_W-CNT_W){1'b0}}, cnt_reg} *
                       {{(NUM_W-SCALE_W){1'b0}}, SCALE_MHZ};
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub   = {1'b0, rem_shift} - {2'b00, den_reg};
    assign rem_ge    = ~rem_sub[TIME_W+1];
    assign rem_next  = rem_ge ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
    assign num_next  = {num_reg[NUM_W-2:0], rem_ge};

    always_comb
    begin
        if (!has_quot_reg)
        begin
            reading_next = '0;
        end
        else if (|num_reg[NUM_W-1:READ_W])
        begin
            reading_next = READ_MAX;
        end
        else
        begin
            reading_next = num_reg[READ_W-1:0];
        end
    end

    assign sts.need_div = is_read && (sel_cnt != '0) && (sel_sum != '0);
    assign sts.div_last = div_cnt_reg == DIV_LAST;
    assign sts.out_full = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(operation);
            now_reg   <= now_us;
            pe_reg    <= power_edge;
            me_reg    <= mux_edge;
            pdiff_reg <= now_us - last_power_reg;
            mdiff_reg <= MUXW_W'(now_us - last_mux_reg);
            sdiff_reg <= now_us - last_switch_reg;
        end
        if (cmd.exec)
        begin
            cnt_reg <= sel_cnt;
            den_reg <= sel_sum;
        end
        if (cmd.mul)
        begin
            num_reg <= product;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            reading_out_reg <= reading_next;
            total_out_reg   <= total_reg;
            level_out_reg   <= meas_curr_reg ? cfg.curr_level : ~cfg.curr_level;
            update_out_reg  <= update_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_power_reg  <= '0;
            last_mux_reg    <= '0;
            last_switch_reg <= '0;
            power_sum_reg   <= '0;
            power_cnt_reg   <= '0;
            total_reg       <= '0;
            curr_sum_reg    <= '0;
            curr_cnt_reg    <= '0;
            volt_sum_reg    <= '0;
            volt_cnt_reg    <= '0;
            meas_curr_reg   <= 1'b1;
            update_reg      <= 1'b0;
            has_quot_reg    <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                update_reg   <= 1'b0;
                has_quot_reg <= sts.need_div;
                if (power_hit)
                begin
                    power_sum_reg  <= power_sum_reg + pdiff_reg;
                    power_cnt_reg  <= power_cnt_reg + CNT_W'(1);
                    total_reg      <= total_reg + TIME_W'(1);
                    last_power_reg <= now_reg;
                end
                if (mux_hit)
                begin
                    if (meas_curr_reg)
                    begin
                        curr_sum_reg <= curr_sum_reg + {{(TIME_W-MUXW_W){1'b0}}, mdiff_reg};
                        curr_cnt_reg <= curr_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        volt_sum_reg <= volt_sum_reg + {{(TIME_W-MUXW_W){1'b0}}, mdiff_reg};
                        volt_cnt_reg <= volt_cnt_reg + CNT_W'(1);
                    end
                    last_mux_reg <= now_reg;
                    if (switch_due)
                    begin
                        last_switch_reg <= now_reg;
                        meas_curr_reg   <= ~meas_curr_reg;
                        update_reg      <= cfg.select_en;
                    end
                end
                // A read clears its channel whether or not a quotient is formed.
                unique case (op_reg)
                    OP_READ_VOLT:
                    begin
                        volt_sum_reg <= '0;
                        volt_cnt_reg <= '0;
                    end
                    OP_READ_CURR:
                    begin
                        curr_sum_reg <= '0;
                        curr_cnt_reg <= '0;
                    end
                    OP_READ_POWER:
                    begin
                        power_sum_reg <= '0;
                        power_cnt_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.mul)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign reading_mhz   = reading_out_reg;
    assign total_pulses  = total_out_reg;
    assign select_level  = level_out_reg;
    assign select_update = update_out_reg;

endmodule

// File: rtl/core/energy_pulse_frequency_meter.sv
// A transaction that needs no quotient passes from capture through the update state to
// write-back. That covers edges, energy reads, spare codes and reads of an empty channel.
// A voltage, current or power read with a non-zero count and sum also passes the multiply
// state and the restoring divider, which retires one quotient bit per cycle over 62.
// One transaction at a time: a new one is taken only after the last is written back.
// Reset (rst_n low, asynchronous) clears all sums, counts and edge times, selects current
// mode, empties the output register and loads the register defaults.
module energy_pulse_frequency_meter (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [epfm_pkg::ADDR_W-1:0]   paddr,
    input  logic [epfm_pkg::DATA_W-1:0]   pwdata,
    output logic [epfm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    operation,
    input  logic [epfm_pkg::TIME_W-1:0]   now_us,
    input  logic                          power_edge,
    input  logic                          mux_edge,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [epfm_pkg::READ_W-1:0]   reading_mhz,
    output logic [epfm_pkg::TIME_W-1:0]   total_pulses,
    output logic                          select_level,
    output logic                          select_update
);
    import epfm_pkg::*;

    // The configuration registers live here. Each register sits on a word boundary,
    // so the word index is taken from the address bits above the byte offset. Words
    // beyond the register list read as zero and ignore writes.
    cfg_t     cfg_reg;
    reg_idx_t cfg_idx;
    logic     cfg_wr;
    cmd_t     cmd;
    sts_t     sts;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_en   <= 1'b0;
            cfg_reg.mux_en     <= 1'b0;
            cfg_reg.select_en  <= 1'b0;
            cfg_reg.curr_level <= 1'b0;
            cfg_reg.switch_us  <= SWITCH_US_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_POWER_EN:   cfg_reg.power_en   <= pwdata[0];
                REG_MUX_EN:     cfg_reg.mux_en     <= pwdata[0];
                REG_SELECT_EN:  cfg_reg.select_en  <= pwdata[0];
                REG_CURR_LEVEL: cfg_reg.curr_level <= pwdata[0];
                REG_SWITCH_US:  cfg_reg.switch_us  <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_POWER_EN:   prdata[0] = cfg_reg.power_en;
            REG_MUX_EN:     prdata[0] = cfg_reg.mux_en;
            REG_SELECT_EN:  prdata[0] = cfg_reg.select_en;
            REG_CURR_LEVEL: prdata[0] = cfg_reg.curr_level;
            REG_SWITCH_US:  prdata    = cfg_reg.switch_us;
            default:        prdata    = '0;
        endcase
    end

    // The controller sequences each transaction through capture, update, for divided
    // reads multiply and divide, and write-back. It only accepts a new transaction when
    // idle, but the output register lets it take one while the previous result waits.
    epfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // The datapath holds the measurement state, forms the scaled count with one
    // multiplier and divides it by the width sum in a bit-serial restoring divider.
    epfm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg           (cfg_reg),
        .operation     (operation),
        .now_us        (now_us),
        .power_edge    (power_edge),
        .mux_edge      (mux_edge),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .reading_mhz   (reading_mhz),
        .total_pulses  (total_pulses),
        .select_level  (select_level),
        .select_update (select_update)
    );

endmodule

// File: rtl/core/epfm_checker.sv
`include "energy_pulse_frequency_meter_defines.svh"

module epfm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [epfm_pkg::READ_W-1:0]   reading_mhz,
    input  logic [epfm_pkg::TIME_W-1:0]   total_pulses
);
    import epfm_pkg::*;

    // Pulse total of the last delivered result; the total is zero after reset.
    logic [TIME_W-1:0] last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_total_reg <= total_pulses;
        end
    end

    // Only one transaction is in flight at a time.
    `EPFM_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction accepted while busy")

    // Each transaction adds at most one power pulse to the total.
    `EPFM_ASSERT_IMP(a_total_step, out_valid && out_ready, total_pulses == last_total_reg || total_pulses == last_total_reg + 64'd1, "pulse total moved by more than one")

    // A stalled result is held.
    `EPFM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(reading_mhz) && $stable(total_pulses), "stalled result changed")

endmodule

bind energy_pulse_frequency_meter epfm_checker u_epfm_checker (.*);
